FILE: sv/contact_force_torque_estimator_assert.svh
// assertion macros for the contact force/torque estimator
// expects clk and arst_n in the scope where the macros are used
`ifndef CONTACT_FORCE_TORQUE_ESTIMATOR_ASSERT_SVH
`define CONTACT_FORCE_TORQUE_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define CFTE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("contact estimator check failed");

// next-cycle implication
`define CFTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("contact estimator check failed");

`endif

FILE: sv/cfte_pkg.sv
// shared types, widths and codes for the contact force/torque estimator
// no dependencies
`default_nettype none

package cfte_pkg;

	localparam int NUM_CELLS_DEF = 6;
	localparam int FSUM_W        = 35;
	localparam int TSUM_W        = 52;
	localparam int CFG_W         = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int DEN_W         = 72;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_IX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_IY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_IZ    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_DT2  = 3'd4;

	// vector kinds
	localparam logic [2:0] KIND_FORCE  = 3'd0;
	localparam logic [2:0] KIND_TORQUE = 3'd1;
	localparam logic [2:0] KIND_POINT  = 3'd2;
	localparam logic [2:0] KIND_LA     = 3'd3;
	localparam logic [2:0] KIND_AA     = 3'd4;
	localparam logic [2:0] KIND_LD     = 3'd5;
	localparam logic [2:0] KIND_AD     = 3'd6;

	// multiplier operations
	localparam logic [2:0] MOP_SQ = 3'd0;
	localparam logic [2:0] MOP_CA = 3'd1;
	localparam logic [2:0] MOP_CB = 3'd2;
	localparam logic [2:0] MOP_LA = 3'd3;
	localparam logic [2:0] MOP_AA = 3'd4;
	localparam logic [2:0] MOP_LD = 3'd5;
	localparam logic [2:0] MOP_AD = 3'd6;

	typedef struct packed {
		logic [2:0]         cell_index;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic               frame_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         vector_kind;
		logic signed [63:0] comp_x;
		logic signed [63:0] comp_y;
		logic signed [63:0] comp_z;
		logic               last_of_run;
	} out_item_t;

	typedef struct packed {
		logic       mul_start;
		logic       div_start;
		logic       emit;
		logic       clear;
		logic [2:0] op;
		logic [2:0] kind;
		logic [1:0] comp;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: sv/cfte_mul.sv
// shared 64x64 signed multiplier, one 64x16 partial product per cycle
// no package dependency
`default_nettype none

module cfte_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  a,
	input  logic signed [63:0]  b,
	output logic                done,
	output logic signed [127:0] prod
);

	localparam int DIG_W     = 16;
	localparam int MUL_STEPS = 64 / DIG_W;

	logic [63:0]         am_q, bm_q, hi_q, lo_q;
	logic                neg_q, busy_q, done_q;
	logic [2:0]          cnt_q;
	logic signed [127:0] prod_q;
	logic [79:0]         pp, t;
	logic [127:0]        mag;
	logic [63:0]         a_abs, b_abs;

	assign a_abs = a[63] ? (~a + 64'd1) : a;
	assign b_abs = b[63] ? (~b + 64'd1) : b;
	assign pp    = am_q * bm_q[DIG_W-1:0];
	assign t     = {16'd0, hi_q} + pp;
	assign mag   = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'(MUL_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a_abs;
			bm_q  <= b_abs;
			neg_q <= a[63] ^ b[63];
			hi_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'(MUL_STEPS)) begin
				// low digit retires into lo, running sum shifts down
				hi_q <= t[79:16];
				lo_q <= {t[15:0], lo_q[63:16]};
				bm_q <= bm_q >> DIG_W;
			end else begin
				prod_q <= neg_q ? (~mag + 128'd1) : mag;
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

FILE: sv/cfte_div.sv
// restoring divider for the contact point: signed num * 2^16 / den, one bit a cycle
// uses cfte_pkg for the divisor width
`default_nettype none

module cfte_div import cfte_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [127:0]        num,
	input  logic [DEN_W-1:0]    den,
	output logic                done,
	output logic signed [63:0]  quo
);

	localparam int DIV_STEPS = 128;

	logic [127:0]       m_q, num_abs;
	logic [DEN_W-1:0]   rem_q;
	logic [63:0]        q_q;
	logic               ovf_q, neg_q, busy_q, done_q;
	logic [7:0]         cnt_q;
	logic signed [63:0] quo_q;
	logic [DEN_W:0]     sh, diff;
	logic               ge, sat;

	assign num_abs = num[127] ? (~num + 128'd1) : num;
	assign sh      = {rem_q, m_q[127]};
	assign ge      = sh >= {1'b0, den};
	assign diff    = sh - {1'b0, den};
	assign sat     = ovf_q | q_q[63];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 8'(DIV_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[127];
			m_q   <= num_abs << 16;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q != 8'(DIV_STEPS)) begin
				rem_q <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
				m_q   <= m_q << 1;
				q_q   <= {q_q[62:0], ge};
				// any quotient bit above bit 62 means saturation
				ovf_q <= ovf_q | q_q[63];
			end else if (sat) begin
				quo_q <= neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			end else begin
				quo_q <= neg_q ? (~q_q + 64'd1) : q_q;
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

FILE: sv/cfte_datapath.sv
// datapath: config registers, force/torque sums, shared multiplier and divider,
// intermediate vectors and the output register; uses cfte_pkg, cfte_mul, cfte_div
`default_nettype none

module cfte_datapath import cfte_pkg::*; #(
	parameter int NUM_CELLS = NUM_CELLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 sample_accept,
	input  in_item_t             sample,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic                 result_valid,
	input  logic                 result_ready,
	output out_item_t            result
);

	localparam logic signed [16:0] POS_HALF = 17'sd32768;
	localparam logic signed [16:0] POS_QTR  = 17'sd16384;
	localparam logic signed [16:0] POS_SIN  = 17'sd28377;
	localparam logic [2:0]         HEX_CELLS = 3'd6;
	localparam logic [DEN_W-1:0]   FSQ_FLOOR = 72'd4;

	function automatic logic signed [16:0] cell_y(input logic [2:0] idx);
		case (idx)
			3'd0:    return POS_HALF;
			3'd1:    return POS_QTR;
			3'd2:    return -POS_QTR;
			3'd3:    return -POS_HALF;
			3'd4:    return -POS_QTR;
			3'd5:    return POS_QTR;
			default: return 17'sd0;
		endcase
	endfunction

	function automatic logic signed [16:0] cell_z(input logic [2:0] idx);
		case (idx)
			3'd1, 3'd2: return POS_SIN;
			3'd4, 3'd5: return -POS_SIN;
			default:    return 17'sd0;
		endcase
	endfunction

	// lever arms along y are powers of two
	function automatic logic signed [48:0] yscale(input logic signed [31:0] f,
			input logic signed [16:0] ry);
		logic signed [48:0] fe;
		fe = 49'(f);
		case (ry)
			POS_HALF:  return fe <<< 15;
			POS_QTR:   return fe <<< 14;
			-POS_QTR:  return -(fe <<< 14);
			-POS_HALF: return -(fe <<< 15);
			default:   return 49'sd0;
		endcase
	endfunction

	function automatic logic signed [48:0] zscale(input logic signed [31:0] f,
			input logic signed [16:0] rz);
		logic signed [48:0] p;
		p = 49'(f) * 49'(POS_SIN);
		case (rz)
			POS_SIN:  return p;
			-POS_SIN: return -p;
			default:  return 49'sd0;
		endcase
	endfunction

	function automatic logic signed [FSUM_W-1:0] sat_f(input logic signed [FSUM_W:0] v);
		if (v[FSUM_W] == v[FSUM_W-1]) return v[FSUM_W-1:0];
		return v[FSUM_W] ? {1'b1, {(FSUM_W-1){1'b0}}} : {1'b0, {(FSUM_W-1){1'b1}}};
	endfunction

	function automatic logic signed [TSUM_W-1:0] sat_t(input logic signed [TSUM_W+1:0] v);
		if (v[TSUM_W+1:TSUM_W-1] == {3{v[TSUM_W+1]}}) return v[TSUM_W-1:0];
		return v[TSUM_W+1] ? {1'b1, {(TSUM_W-1){1'b0}}} : {1'b0, {(TSUM_W-1){1'b1}}};
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
		if (v[127:63] == {65{v[127]}}) return v[63:0];
		return v[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
	endfunction

	// configuration
	logic [CFG_W-1:0] inv_mass_q, half_dt2_q;
	logic [CFG_W-1:0] inv_inertia_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q       <= 32'd1311;
			inv_inertia_q[0] <= 32'd13107;
			inv_inertia_q[1] <= 32'd13107;
			inv_inertia_q[2] <= 32'd6554;
			half_dt2_q       <= 32'd2199023;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INV_MASS: inv_mass_q       <= cfg_data;
				REG_INV_IX:   inv_inertia_q[0] <= cfg_data;
				REG_INV_IY:   inv_inertia_q[1] <= cfg_data;
				REG_INV_IZ:   inv_inertia_q[2] <= cfg_data;
				REG_HALF_DT2: half_dt2_q       <= cfg_data;
				default:      ;
			endcase
		end
	end

	// input stage, sums update in the cycle after the item is taken
	in_item_t smp_s1;
	logic     vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= sample_accept;
	end

	always_ff @(posedge clk) begin
		if (sample_accept) smp_s1 <= sample;
	end

	logic               known;
	logic signed [16:0] ry, rz;
	logic signed [48:0] yfx, yfz, zfx, zfy;
	logic signed [49:0] dt [3];
	logic signed [31:0] fin [3];

	assign known = (int'(smp_s1.cell_index) < NUM_CELLS) && (smp_s1.cell_index < HEX_CELLS);
	assign ry    = known ? cell_y(smp_s1.cell_index) : 17'sd0;
	assign rz    = known ? cell_z(smp_s1.cell_index) : 17'sd0;
	assign yfx   = yscale(smp_s1.force_x, ry);
	assign yfz   = yscale(smp_s1.force_z, ry);
	assign zfx   = zscale(smp_s1.force_x, rz);
	assign zfy   = zscale(smp_s1.force_y, rz);
	assign dt[0] = 50'(yfz) - 50'(zfy);
	assign dt[1] = 50'(zfx);
	assign dt[2] = -50'(yfx);
	assign fin[0] = smp_s1.force_x;
	assign fin[1] = smp_s1.force_y;
	assign fin[2] = smp_s1.force_z;

	logic signed [FSUM_W-1:0] fsum_q [3];
	logic signed [TSUM_W-1:0] tsum_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				fsum_q[i] <= '0;
				tsum_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < 3; i++) begin
				fsum_q[i] <= '0;
				tsum_q[i] <= '0;
			end
		end else if (vld_s1) begin
			for (int i = 0; i < 3; i++) begin
				fsum_q[i] <= sat_f((FSUM_W+1)'(fsum_q[i]) + (FSUM_W+1)'(fin[i]));
				tsum_q[i] <= sat_t((TSUM_W+2)'(tsum_q[i]) + (TSUM_W+2)'(dt[i]));
			end
		end
	end

	// operand selection for the shared multiplier
	logic [1:0]               na, nb, fidx, tidx;
	logic signed [FSUM_W-1:0] fsel;
	logic signed [TSUM_W-1:0] tsel;
	logic signed [63:0]       mul_a, mul_b;
	logic signed [63:0]       la_q [3];
	logic signed [63:0]       aa_q [3];
	logic signed [63:0]       vec_q [3];

	always_comb begin
		case (cmd.comp)
			2'd0:    begin na = 2'd1; nb = 2'd2; end
			2'd1:    begin na = 2'd2; nb = 2'd0; end
			default: begin na = 2'd0; nb = 2'd1; end
		endcase
		fidx = cmd.comp;
		tidx = cmd.comp;
		case (cmd.op)
			MOP_CA:  begin fidx = na; tidx = nb; end
			MOP_CB:  begin fidx = nb; tidx = na; end
			default: ;
		endcase
	end

	assign fsel = fsum_q[fidx];
	assign tsel = tsum_q[tidx];

	always_comb begin
		case (cmd.op)
			MOP_SQ:         begin mul_a = 64'(fsel); mul_b = 64'(fsel); end
			MOP_CA, MOP_CB: begin mul_a = 64'(tsel); mul_b = 64'(fsel); end
			MOP_LA:         begin mul_a = 64'(fsel); mul_b = {32'd0, inv_mass_q}; end
			MOP_AA: begin
				mul_a = 64'(tsel);
				mul_b = {32'd0, inv_inertia_q[cmd.comp]};
			end
			MOP_LD:         begin mul_a = la_q[cmd.comp]; mul_b = {32'd0, half_dt2_q}; end
			default:        begin mul_a = aa_q[cmd.comp]; mul_b = {32'd0, half_dt2_q}; end
		endcase
	end

	logic                mul_done, div_done;
	logic signed [127:0] mul_prod;
	logic signed [63:0]  div_quo;
	logic signed [127:0] cacc_q;
	logic [DEN_W-1:0]    fsq_q;
	logic [2:0]          wb_op_q;
	logic [1:0]          wb_comp_q;
	logic                fsq_small;

	cfte_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	cfte_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cacc_q),
		.den    (fsq_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign fsq_small = fsq_q <= FSQ_FLOOR;

	always_ff @(posedge clk) begin
		if (cmd.mul_start || cmd.div_start) begin
			wb_op_q   <= cmd.op;
			wb_comp_q <= cmd.comp;
		end
		if (mul_done) begin
			case (wb_op_q)
				MOP_SQ: fsq_q <= (wb_comp_q == 2'd0) ? mul_prod[DEN_W-1:0]
				                                     : fsq_q + mul_prod[DEN_W-1:0];
				MOP_CA: cacc_q <= mul_prod;
				MOP_CB: cacc_q <= cacc_q - mul_prod;
				MOP_LA: la_q[wb_comp_q] <= sat64(mul_prod);
				MOP_AA: aa_q[wb_comp_q] <= sat64(mul_prod >>> 16);
				MOP_LD, MOP_AD: vec_q[wb_comp_q] <= sat64(mul_prod >>> 40);
				default: ;
			endcase
		end
		if (div_done) begin
			// no usable net force: contact point reads as zero
			vec_q[wb_comp_q] <= fsq_small ? 64'sd0 : div_quo;
		end
	end

	// output register
	out_item_t result_q;
	logic      rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)              rvalid_q <= 1'b0;
		else if (cmd.emit)        rvalid_q <= 1'b1;
		else if (result_ready)    rvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.vector_kind <= cmd.kind;
			result_q.last_of_run <= (cmd.kind == KIND_AD);
			case (cmd.kind)
				KIND_FORCE: begin
					result_q.comp_x <= 64'(fsum_q[0]) <<< 16;
					result_q.comp_y <= 64'(fsum_q[1]) <<< 16;
					result_q.comp_z <= 64'(fsum_q[2]) <<< 16;
				end
				KIND_TORQUE: begin
					result_q.comp_x <= 64'(tsum_q[0]);
					result_q.comp_y <= 64'(tsum_q[1]);
					result_q.comp_z <= 64'(tsum_q[2]);
				end
				KIND_LA: begin
					result_q.comp_x <= la_q[0];
					result_q.comp_y <= la_q[1];
					result_q.comp_z <= la_q[2];
				end
				KIND_AA: begin
					result_q.comp_x <= aa_q[0];
					result_q.comp_y <= aa_q[1];
					result_q.comp_z <= aa_q[2];
				end
				default: begin
					result_q.comp_x <= vec_q[0];
					result_q.comp_y <= vec_q[1];
					result_q.comp_z <= vec_q[2];
				end
			endcase
		end
	end

	assign result_valid  = rvalid_q;
	assign result        = result_q;
	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;
	assign stat.out_free = !rvalid_q || result_ready;

endmodule

`default_nettype wire

FILE: sv/cfte_ctrl.sv
// controller: steps through the frame-end sequence of products, divisions and emits
// uses cfte_pkg for command/status types and codes
`default_nettype none

module cfte_ctrl import cfte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  sample_accept,
	input  logic  frame_end,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  sample_ready
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SETTLE = 2'd1;
	localparam logic [1:0] S_RUN    = 2'd2;
	localparam logic [1:0] S_WAIT   = 2'd3;

	localparam logic [3:0] STG_F   = 4'd0;
	localparam logic [3:0] STG_T   = 4'd1;
	localparam logic [3:0] STG_SQ  = 4'd2;
	localparam logic [3:0] STG_CA  = 4'd3;
	localparam logic [3:0] STG_CB  = 4'd4;
	localparam logic [3:0] STG_DV  = 4'd5;
	localparam logic [3:0] STG_P   = 4'd6;
	localparam logic [3:0] STG_LA  = 4'd7;
	localparam logic [3:0] STG_LAE = 4'd8;
	localparam logic [3:0] STG_AA  = 4'd9;
	localparam logic [3:0] STG_AAE = 4'd10;
	localparam logic [3:0] STG_LD  = 4'd11;
	localparam logic [3:0] STG_LDE = 4'd12;
	localparam logic [3:0] STG_AD  = 4'd13;
	localparam logic [3:0] STG_ADE = 4'd14;

	logic [1:0] state_q;
	logic [3:0] stage_q, stage_d;
	logic [1:0] comp_q, comp_d;
	logic       is_emit, is_div, step_done;
	logic [2:0] kind, op;

	always_comb begin
		is_emit = 1'b0;
		is_div  = 1'b0;
		kind    = KIND_FORCE;
		op      = MOP_SQ;
		case (stage_q)
			STG_F:   begin is_emit = 1'b1; kind = KIND_FORCE; end
			STG_T:   begin is_emit = 1'b1; kind = KIND_TORQUE; end
			STG_SQ:  op = MOP_SQ;
			STG_CA:  op = MOP_CA;
			STG_CB:  op = MOP_CB;
			STG_DV:  is_div = 1'b1;
			STG_P:   begin is_emit = 1'b1; kind = KIND_POINT; end
			STG_LA:  op = MOP_LA;
			STG_LAE: begin is_emit = 1'b1; kind = KIND_LA; end
			STG_AA:  op = MOP_AA;
			STG_AAE: begin is_emit = 1'b1; kind = KIND_AA; end
			STG_LD:  op = MOP_LD;
			STG_LDE: begin is_emit = 1'b1; kind = KIND_LD; end
			STG_AD:  op = MOP_AD;
			default: begin is_emit = 1'b1; kind = KIND_AD; end
		endcase
	end

	always_comb begin
		cmd.emit      = (state_q == S_RUN) && is_emit && stat.out_free;
		cmd.mul_start = (state_q == S_RUN) && !is_emit && !is_div;
		cmd.div_start = (state_q == S_RUN) && is_div;
		cmd.clear     = cmd.emit && (stage_q == STG_ADE);
		cmd.op        = op;
		cmd.kind      = kind;
		cmd.comp      = comp_q;
	end

	assign step_done = cmd.emit || ((state_q == S_WAIT) && (stat.mul_done || stat.div_done));

	always_comb begin
		stage_d = stage_q + 4'd1;
		comp_d  = comp_q;
		case (stage_q)
			STG_SQ, STG_LA, STG_AA, STG_LD, STG_AD: begin
				// per-axis loop over the shared multiplier
				if (comp_q == 2'd2) comp_d = 2'd0;
				else begin
					stage_d = stage_q;
					comp_d  = comp_q + 2'd1;
				end
			end
			STG_DV: begin
				if (comp_q == 2'd2) begin
					stage_d = STG_P;
					comp_d  = 2'd0;
				end else begin
					stage_d = STG_CA;
					comp_d  = comp_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= STG_F;
			comp_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (sample_accept && frame_end) state_q <= S_SETTLE;
				end
				S_SETTLE: begin
					state_q <= S_RUN;
					stage_q <= STG_F;
					comp_q  <= '0;
				end
				S_RUN: begin
					if (cmd.mul_start || cmd.div_start) begin
						state_q <= S_WAIT;
					end else if (step_done) begin
						stage_q <= stage_d;
						comp_q  <= comp_d;
						if (stage_q == STG_ADE) state_q <= S_IDLE;
					end
				end
				S_WAIT: begin
					if (step_done) begin
						state_q <= S_RUN;
						stage_q <= stage_d;
						comp_q  <= comp_d;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_ready = (state_q == S_IDLE);

endmodule

`default_nettype wire

FILE: sv/contact_force_torque_estimator.sv
// Contact force/torque estimator: top level.
// sample channel (valid/ready) carries one load-cell force per item with its cell index;
// result channel (valid/ready) carries seven Q32.32 vectors per frame, kinds in order
// force, torque, contact point, linear accel, angular accel, linear and angular disp.
// cfg channel writes the five reciprocal/interval registers; cfg_ready is always high.
// Items without frame_end are taken one per cycle, registered, then added to the sums.
// An item with frame_end stops intake until the seventh vector of that frame is loaded
// into the output register, a wait set by the bit-serial divider (three
// 128-step quotients for the contact point) and the shared multiplier, which takes one
// 64x16 partial product per cycle over 21 products.
// The first vector of a frame follows the settle state, once the output is free.
// A stalled receiver holds the output register; the sequence then waits for it, so
// nothing is lost. The last vector may wait while the next frame is already taken in.
// Reset clears the sums and the handshake state and loads the register defaults.
`default_nettype none

module contact_force_torque_estimator import cfte_pkg::*; #(
	parameter int NUM_CELLS = NUM_CELLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  in_item_t             sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output out_item_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t  cmd;
	stat_t stat;
	logic  sample_accept;

	assign sample_accept = sample_valid && sample_ready;
	assign cfg_ready     = 1'b1;

	cfte_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_accept (sample_accept),
		.frame_end     (sample.frame_end),
		.stat          (stat),
		.cmd           (cmd),
		.sample_ready  (sample_ready)
	);

	cfte_datapath #(
		.NUM_CELLS (NUM_CELLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_accept (sample_accept),
		.sample        (sample),
		.cmd           (cmd),
		.stat          (stat),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result)
	);

`include "contact_force_torque_estimator_assert.svh"

	`CFTE_ASSERT_NOW(a_last_kind, result_valid && result.last_of_run, result.vector_kind == KIND_AD)
	`CFTE_ASSERT_NEXT(a_frame_blocks, sample_accept && sample.frame_end, !sample_ready)
	`CFTE_ASSERT_NOW(a_one_action, cmd.mul_start || cmd.div_start, !cmd.emit && !sample_ready)
	`CFTE_ASSERT_NEXT(a_emit_shows, cmd.emit, result_valid)

endmodule

`default_nettype wire
